/* hdl/tcs_pkg.sv */
// tcs_pkg: shared types, register indexes, palette table and color lookup
// for the top-down column shader. No dependencies.
package tcs_pkg;

   // Palette size and job queue depth
   localparam int TABLE_ENTRIES     = 50;
   localparam int QUEUE_DEPTH_DEF   = 2;

   // Saturation limit of the water counter
   localparam logic [8:0] WATER_MAX = 9'd511;

   // Configuration register indexes
   localparam logic [2:0] CSR_AIR_CODE         = 3'd0;
   localparam logic [2:0] CSR_WATER_CODE       = 3'd1;
   localparam logic [2:0] CSR_STILL_WATER_CODE = 3'd2;
   localparam logic [2:0] CSR_FALLBACK_CODE    = 3'd3;
   localparam logic [2:0] CSR_ROTATION         = 3'd4;
   localparam logic [2:0] CSR_SIZE_X           = 3'd5;
   localparam logic [2:0] CSR_SIZE_Z           = 3'd6;

   // Rotation codes
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   // Configuration registers as one bundle
   typedef struct packed {
      logic [7:0] air_code;
      logic [7:0] water_code;
      logic [7:0] still_water_code;
      logic [5:0] fallback_code;
      logic [1:0] rotation;
      logic [8:0] size_x;
      logic [8:0] size_z;
   } cfg_type;

   // One finished column scan, handed from the front to the back
   typedef struct packed {
      logic [7:0] col_x;
      logic [7:0] col_z;
      logic [7:0] base_code;
      logic [8:0] water_count;
   } job_type;

   // Fixed ARGB palette
   function automatic logic [31:0] palette_entry(input logic [5:0] idx);
      logic [31:0] c;
      case (idx)
         6'd0:  c = 32'h00000000;  6'd1:  c = 32'hFF7D7D7D;
         6'd2:  c = 32'hFF75B049;  6'd3:  c = 32'hFF866043;
         6'd4:  c = 32'hFF757575;  6'd5:  c = 32'hFF9D804F;
         6'd6:  c = 32'h6C518117;  6'd7:  c = 32'hFF545454;
         6'd8:  c = 32'h8A2A5EFF;  6'd9:  c = 32'h8A2A5EFF;
         6'd10: c = 32'hFFF54100;  6'd11: c = 32'hFFF54100;
         6'd12: c = 32'hFFDAD29E;  6'd13: c = 32'hFF887E7E;
         6'd14: c = 32'hFF8F8C7D;  6'd15: c = 32'hFF88827F;
         6'd16: c = 32'hFF737373;  6'd17: c = 32'hFF665132;
         6'd18: c = 32'h9A3CBF29;  6'd19: c = 32'hFFB6B639;
         6'd20: c = 32'h47DAF1F4;  6'd21: c = 32'hFFDE3232;
         6'd22: c = 32'hFFDE8832;  6'd23: c = 32'hFFDEDE32;
         6'd24: c = 32'hFF88DE32;  6'd25: c = 32'hFF32DE32;
         6'd26: c = 32'hFF32DE88;  6'd27: c = 32'hFF32DEDE;
         6'd28: c = 32'hFF68A3DE;  6'd29: c = 32'hFF7878DE;
         6'd30: c = 32'hFF8832DE;  6'd31: c = 32'hFFAE4ADE;
         6'd32: c = 32'hFFDE32DE;  6'd33: c = 32'hFFDE3288;
         6'd34: c = 32'hFF4D4D4D;  6'd35: c = 32'hFF8F8F8F;
         6'd36: c = 32'hFFDEDEDE;  6'd37: c = 32'h1F6CA201;
         6'd38: c = 32'h1E8B2C0D;  6'd39: c = 32'h1A8A6A54;
         6'd40: c = 32'h22C33638;  6'd41: c = 32'hFFFFF144;
         6'd42: c = 32'hFFE6E6E6;  6'd43: c = 32'hFF9F9F9F;
         6'd44: c = 32'hFF9F9F9F;  6'd45: c = 32'hFFC66A50;
         6'd46: c = 32'hFF82412F;  6'd47: c = 32'hFF6C583A;
         6'd48: c = 32'hFF5B6C5B;  6'd49: c = 32'hFF14121E;
         default: c = 32'h00000000;
      endcase
      return c;
   endfunction

   // Color of a block code, with fallback for codes beyond the palette
   function automatic logic [31:0] colour_of(input logic [7:0] code,
                                             input logic [5:0] fallback);
      logic [31:0] c;
      if (code < 8'(TABLE_ENTRIES)) begin
         c = palette_entry(code[5:0]);
      end else if (fallback < 6'(TABLE_ENTRIES)) begin
         c = palette_entry(fallback);
      end else begin
         c = palette_entry(6'd0);
      end
      return c;
   endfunction

endpackage

/* hdl/tcs_front.sv */
// tcs_front: column scanner. Classifies each block code, tracks water count
// and surface code, and queues one job per column. Uses tcs_pkg.
module tcs_front (
   input  logic              clock,
   input  logic              reset,
   input  tcs_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_col_x,
   input  logic [7:0]        req_col_z,
   input  logic [7:0]        req_block_code,
   input  logic              req_bottom,
   input  logic              q_full,
   output logic              q_push,
   output tcs_pkg::job_type  q_job
);

   logic [8:0] water_count_ff, water_count_in;
   logic       solid_found_ff, solid_found_in;
   logic [7:0] surface_code_ff, surface_code_in;

   logic       accept;
   logic       is_air;
   logic       is_water;
   logic [8:0] count_step;
   logic       solid_step;
   logic [7:0] surface_step;
   logic [7:0] base_code;

   // Hold off the scan while no queue slot is free
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Classify: air is tested before water
   assign is_air   = (req_block_code == cfg.air_code);
   assign is_water = !is_air && ((req_block_code == cfg.water_code) ||
                                 (req_block_code == cfg.still_water_code));

   // Column state after this block
   always_comb begin
      count_step   = water_count_ff;
      solid_step   = solid_found_ff;
      surface_step = surface_code_ff;
      if (!solid_found_ff) begin
         if (is_air) begin
            count_step = water_count_ff;
         end else if (is_water) begin
            if (water_count_ff != tcs_pkg::WATER_MAX) begin
               count_step = water_count_ff + 9'd1;
            end
         end else begin
            solid_step   = 1'b1;
            surface_step = req_block_code;
         end
      end
   end

   // Base color code when the column ends here
   always_comb begin
      if (solid_step) begin
         base_code = surface_step;
      end else if (is_water) begin
         base_code = cfg.water_code;
      end else begin
         base_code = req_block_code;
      end
   end

   // Job for the shading back end
   assign q_push            = accept && req_bottom;
   assign q_job.col_x       = req_col_x;
   assign q_job.col_z       = req_col_z;
   assign q_job.base_code   = base_code;
   assign q_job.water_count = count_step;

   // Next state: clear at the bottom of each column
   always_comb begin
      water_count_in  = water_count_ff;
      solid_found_in  = solid_found_ff;
      surface_code_in = surface_code_ff;
      if (accept) begin
         if (req_bottom) begin
            water_count_in  = 9'd0;
            solid_found_in  = 1'b0;
            surface_code_in = 8'd0;
         end else begin
            water_count_in  = count_step;
            solid_found_in  = solid_step;
            surface_code_in = surface_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         water_count_ff  <= 9'd0;
         solid_found_ff  <= 1'b0;
         surface_code_ff <= 8'd0;
      end else begin
         water_count_ff  <= water_count_in;
         solid_found_ff  <= solid_found_in;
         surface_code_ff <= surface_code_in;
      end
   end

endmodule

/* hdl/tcs_queue.sv */
// tcs_queue: small job FIFO between the scanner and the shading back end.
// Uses tcs_pkg for the job type.
module tcs_queue #(
   parameter int DEPTH = tcs_pkg::QUEUE_DEPTH_DEF,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcs_pkg::job_type  push_job,
   input  logic              pop,
   output tcs_pkg::job_type  head_job,
   output logic              empty,
   output logic              full,
   output logic [CNT_W-1:0]  level
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   tcs_pkg::job_type  slot_ff [DEPTH];
   logic [IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  level_ff, level_in;

   assign empty    = (level_ff == '0);
   assign full     = (level_ff == CNT_W'(DEPTH));
   assign level    = level_ff;
   assign head_job = slot_ff[rd_ptr_ff];

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + CNT_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hdl/tcs_back.sv */
// tcs_back: shading back end. Looks up colors, blends water once per cycle,
// forms the rotated address and holds the result register. Uses tcs_pkg.
module tcs_back (
   input  logic              clock,
   input  logic              reset,
   input  tcs_pkg::cfg_type  cfg,
   input  logic              q_empty,
   input  tcs_pkg::job_type  q_job,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [15:0]       rsp_pixel_index,
   output logic [31:0]       rsp_pixel_bgra
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_MIX  = 1'b1;

   logic        state_ff, state_in;
   logic [8:0]  count_ff, count_in;
   logic [7:0]  red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [7:0]  alpha_ff, alpha_in;
   logic [7:0]  wr_ff, wr_in, wg_ff, wg_in, wb_ff, wb_in, wa_ff, wa_in;
   logic [7:0]  x_ff, x_in, z_ff, z_in;
   logic [15:0] pzx_ff, pzx_in, pxz_ff, pxz_in, psq_ff, psq_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_index_ff, rsp_index_in;
   logic [31:0] rsp_bgra_ff, rsp_bgra_in;

   logic [31:0] base_c;
   logic [31:0] water_c;
   logic [16:0] prod_zx;
   logic [16:0] prod_xz;
   logic [17:0] prod_sq;
   logic [15:0] sx16, sz16, x16, z16;
   logic [15:0] address;
   logic        out_free;

   // One blend step of a channel: (w*wa + c*(255-wa)) / 255
   function automatic logic [7:0] mix(input logic [7:0] w, input logic [7:0] c,
                                      input logic [7:0] wa);
      logic [16:0] v;
      logic [16:0] q;
      v = 17'(w * wa) + 17'(c * (8'd255 - wa));
      q = (v + 17'd1 + (v >> 8)) >> 8;
      return q[7:0];
   endfunction

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;

   // Palette lookups and address products for the job at the queue head
   assign base_c  = tcs_pkg::colour_of(q_job.base_code, cfg.fallback_code);
   assign water_c = tcs_pkg::colour_of(cfg.water_code, cfg.fallback_code);
   assign prod_zx = q_job.col_z * cfg.size_x;
   assign prod_xz = q_job.col_x * cfg.size_z;
   assign prod_sq = cfg.size_x * cfg.size_z;

   // Rotated address, modulo 2^16
   assign sx16 = {7'd0, cfg.size_x};
   assign sz16 = {7'd0, cfg.size_z};
   assign x16  = {8'd0, x_ff};
   assign z16  = {8'd0, z_ff};
   always_comb begin
      case (cfg.rotation)
         tcs_pkg::ROT_0:   address = pzx_ff + x16;
         tcs_pkg::ROT_90:  address = psq_ff - sz16 + z16 - pxz_ff;
         tcs_pkg::ROT_180: address = psq_ff - 16'd1 - pzx_ff - x16;
         tcs_pkg::ROT_270: address = sz16 - 16'd1 - z16 + pxz_ff;
         default:          address = pzx_ff + x16;
      endcase
   end

   // Sequencer: load a job, blend count times, then write the result register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      alpha_in     = alpha_ff;
      wr_in        = wr_ff;
      wg_in        = wg_ff;
      wb_in        = wb_ff;
      wa_in        = wa_ff;
      x_in         = x_ff;
      z_in         = z_ff;
      pzx_in       = pzx_ff;
      pxz_in       = pxz_ff;
      psq_in       = psq_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_bgra_in  = rsp_bgra_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               count_in = q_job.water_count;
               alpha_in = base_c[31:24];
               red_in   = base_c[23:16];
               green_in = base_c[15:8];
               blue_in  = base_c[7:0];
               wa_in    = water_c[31:24];
               wr_in    = water_c[23:16];
               wg_in    = water_c[15:8];
               wb_in    = water_c[7:0];
               x_in     = q_job.col_x;
               z_in     = q_job.col_z;
               pzx_in   = prod_zx[15:0];
               pxz_in   = prod_xz[15:0];
               psq_in   = prod_sq[15:0];
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            if (count_ff != 9'd0) begin
               red_in   = mix(wr_ff, red_ff, wa_ff);
               green_in = mix(wg_ff, green_ff, wa_ff);
               blue_in  = mix(wb_ff, blue_ff, wa_ff);
               count_in = count_ff - 9'd1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = address;
               rsp_bgra_in  = {blue_ff, green_ff, red_ff, alpha_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= 9'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      alpha_ff     <= alpha_in;
      wr_ff        <= wr_in;
      wg_ff        <= wg_in;
      wb_ff        <= wb_in;
      wa_ff        <= wa_in;
      x_ff         <= x_in;
      z_ff         <= z_in;
      pzx_ff       <= pzx_in;
      pxz_ff       <= pxz_in;
      psq_ff       <= psq_in;
      rsp_index_ff <= rsp_index_in;
      rsp_bgra_ff  <= rsp_bgra_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = rsp_index_ff;
   assign rsp_pixel_bgra  = rsp_bgra_ff;

endmodule

/* hdl/topdown_column_shader.sv */
// topdown_column_shader: top level. Holds the configuration registers and
// joins scanner, job queue and shading back end. Uses tcs_pkg and all tcs_ modules.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  col_x, col_z, block_code, bottom
//   rsp      out        rsp_valid/rsp_stall  pixel_index, pixel_bgra
//   csr      in         csr_write            csr_index, csr_wdata
//
// The scanner takes one block per cycle while the job queue has room.
// In the back end a pixel takes one blend step per water block, N being the
// column's water count (0 to 511): one blend step per cycle, red, green and blue in parallel.
// Reset is synchronous and clears control state and the configuration registers to defaults.
// A stalled result holds the back end; a full queue then stalls req.
module topdown_column_shader #(
   parameter int QUEUE_DEPTH = tcs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_col_x,
   input  logic [7:0]  req_col_z,
   input  logic [7:0]  req_block_code,
   input  logic        req_bottom,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_pixel_index,
   output logic [31:0] rsp_pixel_bgra,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_wdata
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   tcs_pkg::cfg_type  cfg_ff, cfg_in;
   tcs_pkg::job_type  push_job;
   tcs_pkg::job_type  head_job;
   logic              q_push;
   logic              q_pop;
   logic              q_empty;
   logic              q_full;
   logic [CNT_W-1:0]  q_level;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            tcs_pkg::CSR_AIR_CODE:         cfg_in.air_code         = csr_wdata[7:0];
            tcs_pkg::CSR_WATER_CODE:       cfg_in.water_code       = csr_wdata[7:0];
            tcs_pkg::CSR_STILL_WATER_CODE: cfg_in.still_water_code = csr_wdata[7:0];
            tcs_pkg::CSR_FALLBACK_CODE:    cfg_in.fallback_code    = csr_wdata[5:0];
            tcs_pkg::CSR_ROTATION:         cfg_in.rotation         = csr_wdata[1:0];
            tcs_pkg::CSR_SIZE_X:           cfg_in.size_x           = csr_wdata;
            tcs_pkg::CSR_SIZE_Z:           cfg_in.size_z           = csr_wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.air_code         <= 8'd0;
         cfg_ff.water_code       <= 8'd8;
         cfg_ff.still_water_code <= 8'd9;
         cfg_ff.fallback_code    <= 6'd1;
         cfg_ff.rotation         <= tcs_pkg::ROT_0;
         cfg_ff.size_x           <= 9'd256;
         cfg_ff.size_z           <= 9'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Column scanner
   tcs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_col_x      (req_col_x),
      .req_col_z      (req_col_z),
      .req_block_code (req_block_code),
      .req_bottom     (req_bottom),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_job          (push_job)
   );

   // Job queue
   tcs_queue #(
      .DEPTH (QUEUE_DEPTH),
      .CNT_W (CNT_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full),
      .level    (q_level)
   );

   // Shading back end
   tcs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_empty         (q_empty),
      .q_job           (head_job),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_pixel_bgra  (rsp_pixel_bgra)
   );

`ifndef SYNTHESIS
   // Queue fill level stays within its depth
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      q_level <= CNT_W'(QUEUE_DEPTH))
      else $error("job queue level beyond depth");

   // The back end only takes a job that is there
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_level != '0))
      else $error("job popped from empty queue");

   // A column end never lands on a full queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_level != CNT_W'(QUEUE_DEPTH)))
      else $error("job pushed into full queue");
`endif

endmodule
